### hdl/acss_pkg.sv
// Shared types and constants for the ADC channel scan sequencer.
`timescale 1ns / 1ps

package acss_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_W     = 10;
    localparam int MUX_W        = 8;
    localparam int PHASE_W      = CH_W + 1;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = MAX_CHANNELS * MUX_W;

    // differential channels flip the sample MSB
    localparam int DIFF_BIT = SAMPLE_W - 1;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_TABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MASK     = 2'd2;

    typedef enum logic [1:0] {
        OP_CONV    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]   mux_table;
        logic [COUNT_W-1:0]      channel_count;
        logic [MAX_CHANNELS-1:0] diff_mask;
    } cfg_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     read_index;
    } item_t;

    typedef struct packed {
        logic [MUX_W-1:0]    mux_value;
        logic                frame_captured;
        logic                snapshot_full;
        logic [SAMPLE_W-1:0] read_data;
    } result_t;

endpackage

### hdl/adc_channel_scan_sequencer.sv
// Top level of the ADC channel scan sequencer: stream ports, input and output registers.
`timescale 1ns / 1ps
//
// Usage:
//   s_* carries one word per converter event: tuser selects conversion done,
//   release snapshot or read snapshot entry; tdata carries the sample and the
//   read index. m_* returns exactly one result word per input word: the mux
//   word to apply next, the capture and snapshot-full flags, and read data.
//   cfg_* writes mux_table (index 0), channel_count (1) and diff_mask (2);
//   write only while no word is in flight.
// Path: an accepted word is held in the input register, then its result is
//   loaded into the output register, which drives m_tvalid; that move waits
//   while the output register holds a word that m_tready has not taken.
// Throughput: one word per cycle while m_tready is high; the state update is
//   one short pass from the input register to the output register.
// Reset: phase counter, live values and the held flag clear, registers take
//   their defaults; the snapshot bank holds nothing defined until captured.
// Stall: while m_tready is low the output register holds its word; one more
//   word can wait in the input register before s_tready drops.
//
module adc_channel_scan_sequencer import acss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [9:0] sample, [12:10] read_index
    input  logic [1:0]            s_tuser,  // [1:0] opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // [7:0] mux_value, [8] frame_captured,
                                            // [9] snapshot_full, [19:10] read_data
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    item_fire;

    acss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign item_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.opcode     <= opcode_t'(s_tuser[1:0]);
            in_reg.sample     <= s_tdata[SAMPLE_W-1:0];
            in_reg.read_index <= s_tdata[SAMPLE_W +: CH_W];
        end
    end

    acss_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item      (in_reg),
        .item_fire (item_fire),
        .result    (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.read_data, out_reg.snapshot_full,
                       out_reg.frame_captured, out_reg.mux_value};

    logic [2:0] unused_tdata;
    assign unused_tdata = s_tdata[15:13];

endmodule

### hdl/acss_cfg.sv
// Configuration register file: mux table, channel count and differential mask.
`timescale 1ns / 1ps

module acss_cfg import acss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mux_table     <= '0;
            cfg_reg.channel_count <= COUNT_W'(1);
            cfg_reg.diff_mask     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MUX_TABLE:     cfg_reg.mux_table     <= cfg_data;
                CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[COUNT_W-1:0];
                CFG_DIFF_MASK:     cfg_reg.diff_mask     <= cfg_data[MAX_CHANNELS-1:0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/acss_core.sv
// Scan state: phase counter, live values, snapshot bank and per-word result logic.
`timescale 1ns / 1ps

module acss_core import acss_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    item_fire,
    output result_t result
);

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [SAMPLE_W-1:0] live_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] snap_reg [MAX_CHANNELS];
    logic                held_reg, held_next;

    logic [CH_W-1:0]     cur_ch;
    logic [CH_W-1:0]     next_ch;
    logic [CH_W-1:0]     last_ch;
    logic [SAMPLE_W-1:0] kept_sample;
    logic                keep;
    logic                round_end;
    logic                capture;

    // last channel of the round, count clamped to 1..MAX_CHANNELS
    always_comb begin
        if (cfg.channel_count == '0) begin
            last_ch = '0;
        end else if (cfg.channel_count > COUNT_W'(MAX_CHANNELS)) begin
            last_ch = CH_W'(MAX_CHANNELS - 1);
        end else begin
            last_ch = CH_W'(cfg.channel_count - COUNT_W'(1));
        end
    end

    assign cur_ch = phase_reg[PHASE_W-1:1];

    // diff channels flip MSB; odd phase keeps, even drops the one after a switch
    always_comb begin
        kept_sample = item.sample;
        if (cfg.diff_mask[cur_ch]) begin
            kept_sample[DIFF_BIT] = ~item.sample[DIFF_BIT];
        end
    end

    always_comb begin
        keep       = 1'b0;
        round_end  = 1'b0;
        capture    = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (item.opcode)
            OP_CONV: begin
                keep = phase_reg[0];
                if (phase_reg[0] && cur_ch >= last_ch) begin
                    round_end  = 1'b1;
                    capture    = !held_reg;
                    phase_next = '0;
                    held_next  = 1'b1;
                end else begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            OP_RELEASE: held_next = 1'b0;
            default: ;
        endcase
    end

    assign next_ch = phase_next[PHASE_W-1:1];

    // result word for this item
    always_comb begin
        result.mux_value      = cfg.mux_table[MUX_W*next_ch +: MUX_W];
        result.frame_captured = capture;
        result.snapshot_full  = held_next;
        result.read_data      = (item.opcode == OP_READ) ? snap_reg[item.read_index] : '0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            held_reg  <= 1'b0;
        end else if (item_fire) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // live value array, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                live_reg[i] <= '0;
            end
        end else if (item_fire && keep) begin
            live_reg[cur_ch] <= kept_sample;
        end
    end

    // snapshot bank takes the whole frame, including the word just kept
    always_ff @(posedge aclk) begin
        if (item_fire && capture) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                snap_reg[i] <= (CH_W'(i) == cur_ch) ? kept_sample : live_reg[i];
            end
        end
    end

    logic unused_round_end;
    assign unused_round_end = round_end;

endmodule
